// File: hw/rtl/zzs_pkg.sv
package zzs_pkg;

    // Shape limits and word width
    localparam int MAX_ROWS   = 8;
    localparam int MAX_COLS   = 8;
    localparam int ELEM_WIDTH = 16;

    // Derived sizes
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = 6;
    localparam int CNT_W  = 7;
    localparam int CFG_W  = 3;
    localparam int DIAG_W = CFG_W + 1;
    localparam int IDX_W  = 2;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_LAST_ROW = 2'd0,
        REG_LAST_COL = 2'd1
    } cfg_reg_t;

    // Controller to datapath
    typedef struct packed {
        logic load_en;    // store incoming word
        logic scan_step;  // read one entry and advance the walker
    } zzs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic load_last;  // incoming word completes the matrix
        logic scan_last;  // walker sits on the final entry
    } zzs_status_t;

    // Saturate a last-index register at the shape limit
    function automatic logic [CFG_W-1:0] clamp_idx(input logic [CFG_W-1:0] v,
                                                   input int limit);
        logic [CFG_W-1:0] top;
        top = CFG_W'(limit - 1);
        return (v > top) ? top : v;
    endfunction

endpackage

// File: hw/rtl/zzs_ctrl.sv
module zzs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                element_valid,
    output logic                element_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  zzs_pkg::zzs_status_t status,
    output zzs_pkg::zzs_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_fire;
    logic   issue;

    // Handshake decode
    assign element_stall = (state_reg != ST_LOAD);
    assign in_fire       = element_valid && !element_stall;
    // Read one entry when the output register is empty or being drained
    assign issue         = (state_reg == ST_SCAN) && (!out_valid_reg || !out_stall);

    assign cmd.load_en   = in_fire;
    assign cmd.scan_step = issue;
    assign out_valid     = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && status.load_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue && status.scan_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Output word valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Scan starts only on the word that completes the matrix
    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && ($past(state_reg) == ST_LOAD)
            |-> $past(in_fire && status.load_last))
        else $error("scan entered without completing word");

    // Final read hands control back to loading
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        issue && status.scan_last |=> state_reg == ST_LOAD)
        else $error("scan did not end after final entry");

    // Every read lands in the output register
    a_issue_valid: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> out_valid_reg)
        else $error("read issued but output word not valid");

endmodule

// File: hw/rtl/zzs_datapath.sv
module zzs_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [zzs_pkg::IDX_W-1:0]             cfg_index,
    input  logic [zzs_pkg::CFG_W-1:0]             cfg_data,
    input  logic signed [zzs_pkg::ELEM_WIDTH-1:0] element_value,
    output logic signed [zzs_pkg::ELEM_WIDTH-1:0] out_value,
    output logic                                  end_of_scan,
    input  zzs_pkg::zzs_cmd_t                     cmd,
    output zzs_pkg::zzs_status_t                  status
);

    logic [zzs_pkg::CFG_W-1:0]      last_row_reg;
    logic [zzs_pkg::CFG_W-1:0]      last_col_reg;
    logic [zzs_pkg::CNT_W-1:0]      load_cnt_reg;
    logic [zzs_pkg::CNT_W-1:0]      load_cnt_next;
    logic [zzs_pkg::DIAG_W-1:0]     diag_reg;
    logic [zzs_pkg::DIAG_W-1:0]     diag_next;
    logic [zzs_pkg::CFG_W-1:0]      row_reg;
    logic [zzs_pkg::CFG_W-1:0]      row_next;
    logic [zzs_pkg::ELEM_WIDTH-1:0] rd_data_reg;
    logic                           eos_reg;
    logic [zzs_pkg::ELEM_WIDTH-1:0] mem [0:zzs_pkg::DEPTH-1];

    logic [zzs_pkg::CFG_W-1:0]  lr;
    logic [zzs_pkg::CFG_W-1:0]  lc;
    logic [zzs_pkg::DIAG_W-1:0] ncols;
    logic [zzs_pkg::CNT_W-1:0]  total;
    logic [zzs_pkg::CNT_W-1:0]  load_eff;
    logic [zzs_pkg::CNT_W-1:0]  load_inc;
    logic [zzs_pkg::DIAG_W-1:0] diag_last;
    logic [zzs_pkg::DIAG_W-1:0] diag_inc;
    logic [zzs_pkg::CFG_W-1:0]  rmax_cur;
    logic [zzs_pkg::CFG_W-1:0]  rmin_cur;
    logic [zzs_pkg::CFG_W-1:0]  rmax_nxt;
    logic [zzs_pkg::CFG_W-1:0]  rmin_nxt;
    logic                       diag_end;
    logic [zzs_pkg::CFG_W-1:0]  col;
    logic [zzs_pkg::CNT_W-1:0]  rd_sum;

    // Row at the bottom-left end of an anti-diagonal
    function automatic logic [zzs_pkg::CFG_W-1:0] row_max(
        input logic [zzs_pkg::DIAG_W-1:0] d,
        input logic [zzs_pkg::CFG_W-1:0]  lrow);
        return (d < {1'b0, lrow}) ? d[zzs_pkg::CFG_W-1:0] : lrow;
    endfunction

    // Row at the top-right end of an anti-diagonal
    function automatic logic [zzs_pkg::CFG_W-1:0] row_min(
        input logic [zzs_pkg::DIAG_W-1:0] d,
        input logic [zzs_pkg::CFG_W-1:0]  lcol);
        logic [zzs_pkg::DIAG_W-1:0] cmax;
        logic [zzs_pkg::DIAG_W-1:0] diff;
        cmax = (d < {1'b0, lcol}) ? d : {1'b0, lcol};
        diff = d - cmax;
        return diff[zzs_pkg::CFG_W-1:0];
    endfunction

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_row_reg <= zzs_pkg::CFG_W'(zzs_pkg::MAX_ROWS - 1);
            last_col_reg <= zzs_pkg::CFG_W'(zzs_pkg::MAX_COLS - 1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == zzs_pkg::REG_LAST_ROW)
            begin
                last_row_reg <= cfg_data;
            end
            else if (cfg_index == zzs_pkg::REG_LAST_COL)
            begin
                last_col_reg <= cfg_data;
            end
        end
    end

    // Shape in force
    assign lr    = zzs_pkg::clamp_idx(last_row_reg, zzs_pkg::MAX_ROWS);
    assign lc    = zzs_pkg::clamp_idx(last_col_reg, zzs_pkg::MAX_COLS);
    assign ncols = {1'b0, lc} + 1'b1;
    assign total = (zzs_pkg::CNT_W'(lr) + 1'b1) * zzs_pkg::CNT_W'(ncols);

    // Load counter: restart if a smaller shape was set mid-load
    assign load_eff = (load_cnt_reg >= total) ? '0 : load_cnt_reg;
    assign load_inc = load_eff + 1'b1;
    assign status.load_last = (load_inc == total);

    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        if (cmd.load_en)
        begin
            load_cnt_next = status.load_last ? '0 : load_inc;
        end
    end

    // Zigzag walker over anti-diagonals
    assign diag_last = {1'b0, lr} + {1'b0, lc};
    assign diag_inc  = diag_reg + 1'b1;
    assign rmax_cur  = row_max(diag_reg, lr);
    assign rmin_cur  = row_min(diag_reg, lc);
    assign rmax_nxt  = row_max(diag_inc, lr);
    assign rmin_nxt  = row_min(diag_inc, lc);
    // odd diagonals run downward, even ones upward
    assign diag_end  = diag_reg[0] ? (row_reg == rmax_cur) : (row_reg == rmin_cur);
    assign status.scan_last = diag_end && (diag_reg == diag_last);

    always_comb
    begin
        diag_next = diag_reg;
        row_next  = row_reg;
        if (cmd.scan_step)
        begin
            if (status.scan_last)
            begin
                diag_next = '0;
                row_next  = '0;
            end
            else if (diag_end)
            begin
                diag_next = diag_inc;
                row_next  = diag_inc[0] ? rmin_nxt : rmax_nxt;
            end
            else if (diag_reg[0])
            begin
                row_next = row_reg + 1'b1;
            end
            else
            begin
                row_next = row_reg - 1'b1;
            end
        end
    end

    // Read address: row * pitch + column
    assign col    = zzs_pkg::CFG_W'(diag_reg - {1'b0, row_reg});
    assign rd_sum = zzs_pkg::CNT_W'(row_reg) * zzs_pkg::CNT_W'(ncols)
                  + zzs_pkg::CNT_W'(col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            diag_reg     <= '0;
            row_reg      <= '0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            diag_reg     <= diag_next;
            row_reg      <= row_next;
        end
    end

    // Element buffer, registered read feeds the output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            mem[load_eff[zzs_pkg::ADDR_W-1:0]] <= element_value;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[rd_sum[zzs_pkg::ADDR_W-1:0]];
            eos_reg     <= status.scan_last;
        end
    end

    assign out_value   = rd_data_reg;
    assign end_of_scan = eos_reg;

    // Walker returns to the origin after the final entry
    a_walker_home: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step && status.scan_last |=> (diag_reg == '0) && (row_reg == '0))
        else $error("walker not reset after scan");

    // Walker stays on the matrix
    a_walker_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= lr) && (diag_reg <= diag_last) && (col <= lc))
        else $error("walker left the matrix");

    // Load counter stays inside the buffer
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_cnt_reg < zzs_pkg::CNT_W'(zzs_pkg::DEPTH))
        else $error("load counter out of range");

endmodule

// File: hw/rtl/zigzag_scan_reorder.sv
// Channel   Direction  Handshake                      Word
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
// element   in         element_valid / element_stall  element_value
// out       out        out_valid / out_stall          out_value, end_of_scan
//
// Loading stores one element per accepted handshake; the element that
// completes the matrix starts a scan that reads one entry per cycle from
// the single buffer while the output is not stalled. Input is stalled for
// the whole scan; the output register lets loading of the next matrix
// start while the final word still waits.
// Reset clears the load counter, the walker and restores last_row/last_col = 7.
// A stall on the output holds the scan; no word is dropped or repeated.
module zigzag_scan_reorder
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [zzs_pkg::IDX_W-1:0]             cfg_index,
    input  logic [zzs_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  element_valid,
    output logic                                  element_stall,
    input  logic signed [zzs_pkg::ELEM_WIDTH-1:0] element_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [zzs_pkg::ELEM_WIDTH-1:0] out_value,
    output logic                                  end_of_scan
);

    zzs_pkg::zzs_cmd_t    cmd;
    zzs_pkg::zzs_status_t status;

    // Sequencer
    zzs_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_valid (element_valid),
        .element_stall (element_stall),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .cmd           (cmd)
    );

    // Buffer, counters and address walker
    zzs_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element_value (element_value),
        .out_value     (out_value),
        .end_of_scan   (end_of_scan),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// File: tb/tb_zigzag_scan_reorder.sv
module tb_zigzag_scan_reorder;

    // Run limits
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 150;

    // Register indexes outside the register list
    localparam logic [zzs_pkg::IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [zzs_pkg::IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic signed [zzs_pkg::ELEM_WIDTH-1:0] value;
        logic                                  eos;
    } scan_word_t;

    // Block ports
    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_valid = 1'b0;
    logic                                  cfg_ready;
    logic [zzs_pkg::IDX_W-1:0]             cfg_index = '0;
    logic [zzs_pkg::CFG_W-1:0]             cfg_data = '0;
    logic                                  element_valid = 1'b0;
    logic                                  element_stall;
    logic signed [zzs_pkg::ELEM_WIDTH-1:0] element_value = '0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic signed [zzs_pkg::ELEM_WIDTH-1:0] out_value;
    logic                                  end_of_scan;

    // Shadow copy of the block state
    logic signed [zzs_pkg::ELEM_WIDTH-1:0] shadow_store [zzs_pkg::DEPTH];
    int                                    shadow_count = 0;
    logic [zzs_pkg::CFG_W-1:0]             shadow_last_row = 3'd7;
    logic [zzs_pkg::CFG_W-1:0]             shadow_last_col = 3'd7;

    // Words still to come out, oldest first
    scan_word_t                   scan_words_q [$];

    int  err_cnt = 0;
    int  cycle_cnt = 0;
    bit  quiet = 1'b1;

    zigzag_scan_reorder u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element_valid (element_valid),
        .element_stall (element_stall),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_value     (out_value),
        .end_of_scan   (end_of_scan)
    );

    // Clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("tb_zigzag_scan_reorder: done, errors");
            $finish;
        end
    end

    // Receiver stalls at random unless in a quiet stretch
    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 33);
    end

    // Store one element and, when the matrix is complete, queue its zigzag scan
    function automatic void zigzag_predict(input logic signed [zzs_pkg::ELEM_WIDTH-1:0] v);
        int nr, nc, total, lr, lc, rmax, cmax, rmin, r, c;
        scan_word_t w;
        nr = int'(shadow_last_row) + 1;
        nc = int'(shadow_last_col) + 1;
        total = nr * nc;
        lr = nr - 1;
        lc = nc - 1;
        if (shadow_count >= total)
            shadow_count = 0;
        shadow_store[shadow_count] = v;
        shadow_count++;
        if (shadow_count < total)
            return;
        shadow_count = 0;
        for (int d = 0; d <= lr + lc; d++)
        begin
            rmax = (d < lr) ? d : lr;
            cmax = (d < lc) ? d : lc;
            rmin = d - cmax;
            for (int i = 0; i <= rmax - rmin; i++)
            begin
                r = (d % 2 == 1) ? (rmin + i) : (rmax - i);
                c = d - r;
                w.value = shadow_store[r * nc + c];
                w.eos = 1'b0;
                scan_words_q.push_back(w);
            end
        end
        scan_words_q[scan_words_q.size() - 1].eos = 1'b1;
    endfunction

    function automatic void note_mismatch(input string msg);
        if (err_cnt < 10)
            $display("MISMATCH @%0d: %s", cycle_cnt, msg);
        err_cnt++;
    endfunction

    // Output checker: one word per accepted handshake
    always @(posedge clk)
    begin
        scan_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (scan_words_q.size() == 0)
                note_mismatch($sformatf("unexpected word value %0d eos %0b",
                                        out_value, end_of_scan));
            else
            begin
                w = scan_words_q.pop_front();
                if (out_value !== w.value || end_of_scan !== w.eos)
                    note_mismatch($sformatf("expected value %0d eos %0b, got value %0d eos %0b",
                                            w.value, w.eos, out_value, end_of_scan));
            end
        end
    end

    // Send one element word, with a random gap in front of it
    task automatic send_element(input logic signed [zzs_pkg::ELEM_WIDTH-1:0] v);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < 33) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            element_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        element_valid <= 1'b1;
        element_value <= v;
        do @(posedge clk); while (element_stall);
        zigzag_predict(v);
    endtask

    task automatic end_elements();
        element_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every queued word, then let the block settle
    task automatic wait_drain();
        while (scan_words_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [zzs_pkg::IDX_W-1:0] idx,
                             input logic [zzs_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == zzs_pkg::REG_LAST_ROW)
            shadow_last_row = data;
        else if (idx == zzs_pkg::REG_LAST_COL)
            shadow_last_col = data;
        @(posedge clk);
    endtask

    // Reshape only once the block is idle
    task automatic write_shape(input logic [zzs_pkg::CFG_W-1:0] lrow,
                               input logic [zzs_pkg::CFG_W-1:0] lcol);
        end_elements();
        wait_drain();
        write_reg(zzs_pkg::REG_LAST_ROW, lrow);
        write_reg(zzs_pkg::REG_LAST_COL, lcol);
    endtask

    function automatic logic signed [zzs_pkg::ELEM_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return zzs_pkg::ELEM_WIDTH'($urandom);
        endcase
    endfunction

    // Mostly small shapes, now and then anything up to the full 8x8
    function automatic logic [zzs_pkg::CFG_W-1:0] pick_last_idx();
        if ($urandom_range(0, 9) < 7)
            return zzs_pkg::CFG_W'($urandom_range(0, 3));
        return zzs_pkg::CFG_W'($urandom_range(0, 7));
    endfunction

    // Full 8x8 matrix with the shape left at reset, scan drained without stalls
    task automatic test_reset_shape();
        for (int i = 0; i < zzs_pkg::DEPTH; i++)
            send_element(pick_value());
        end_elements();
        wait_drain();
    endtask

    // 1x1: every word is its own scan
    task automatic test_unit_shape();
        write_shape(3'd0, 3'd0);
        send_element(16'sh8000);
        send_element(16'sh7fff);
        send_element(16'sh0000);
        send_element(16'shffff);
    endtask

    task automatic test_single_row();
        write_shape(3'd0, 3'd2);
        for (int i = 0; i < 3; i++)
            send_element(pick_value());
    endtask

    task automatic test_single_col();
        write_shape(3'd2, 3'd0);
        for (int i = 0; i < 3; i++)
            send_element(pick_value());
    endtask

    // Writes to indexes past the register list leave the shape alone
    task automatic test_spare_indexes();
        write_shape(3'd1, 3'd1);
        write_reg(REG_SPARE_2, 3'd7);
        write_reg(REG_SPARE_3, 3'd0);
        for (int i = 0; i < 4; i++)
            send_element(pick_value());
    endtask

    // Shrinking below the loaded count restarts the matrix
    task automatic test_shrink_mid_load();
        write_shape(3'd1, 3'd1);
        for (int i = 0; i < 3; i++)
            send_element(pick_value());
        write_shape(3'd0, 3'd1);
        for (int i = 0; i < 2; i++)
            send_element(pick_value());
    endtask

    // Growing mid-load keeps the words already stored
    task automatic test_grow_mid_load();
        write_shape(3'd1, 3'd1);
        for (int i = 0; i < 2; i++)
            send_element(pick_value());
        write_shape(3'd2, 3'd1);
        for (int i = 0; i < 4; i++)
            send_element(pick_value());
    endtask

    // Random shapes, whole matrices, spare writes and partial loads
    task automatic test_random();
        int sent, total, n;
        logic [zzs_pkg::CFG_W-1:0] lrow, lcol;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            lrow = pick_last_idx();
            lcol = pick_last_idx();
            write_shape(lrow, lcol);
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          zzs_pkg::CFG_W'($urandom));
            total = (int'(lrow) + 1) * (int'(lcol) + 1);
            n = $urandom_range(1, 3);
            for (int m = 0; m < n; m++)
                for (int i = 0; i < total; i++)
                begin
                    send_element(pick_value());
                    sent++;
                end
            if (total > 1 && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, total - 1);
                for (int i = 0; i < n; i++)
                begin
                    send_element(pick_value());
                    sent++;
                end
            end
        end
        end_elements();
    endtask

    // Main sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        quiet = 1'b1;
        test_reset_shape();
        quiet = 1'b0;
        test_unit_shape();
        test_single_row();
        test_single_col();
        test_spare_indexes();
        test_shrink_mid_load();
        test_grow_mid_load();
        test_random();

        wait_drain();
        if (scan_words_q.size() != 0)
            note_mismatch($sformatf("%0d words never came out", scan_words_q.size()));
        if (err_cnt == 0)
            $display("tb_zigzag_scan_reorder: done, clean");
        else
            $display("tb_zigzag_scan_reorder: done, errors");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/zzs_pkg.sv
hw/rtl/zzs_ctrl.sv
hw/rtl/zzs_datapath.sv
hw/rtl/zigzag_scan_reorder.sv
tb/tb_zigzag_scan_reorder.sv
